/* src/ssi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection package
// Transaction types, queue entry layout, sequencer states and fixed limits.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int MAX_RESULTS = 32;
  localparam int RCW = $clog2(MAX_RESULTS + 1);
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic              set_select;
    logic signed [31:0] value;
    logic              end_of_set;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] common_value;
    logic              last_result;
    logic              empty_result;
    logic              overflow_seen;
  } out_item_t;

  typedef struct packed {
    logic              set_select;
    logic signed [31:0] value;
    logic              keep;
    logic              close;
    logic              overflow;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BUILD_A,
    ST_BUILD_B,
    ST_SCAN,
    ST_PUSH
  } back_state_t;

endpackage

/* src/ssi_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection channels
// Valid/ready channels for input transactions and for result transactions.
// ----------------------------------------------------------------------------
interface ssi_item_if import ssi_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ssi_result_if import ssi_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* src/ssi_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection front end
// Accepts input transactions, tracks set fill and overflow, and tags each
// entry for the back end as kept or dropped and as closing the run.
// ----------------------------------------------------------------------------
module ssi_front import ssi_pkg::*; #(
  parameter int SET_SIZE = 32
) (
  input  logic      clk,
  input  logic      rst,
  ssi_item_if.sink  items,
  output q_entry_t  push_data,
  output logic      push_valid,
  input  logic      push_ready
);

  localparam int CW = $clog2(SET_SIZE + 1);

  logic [CW-1:0] acnt;
  logic [CW-1:0] bcnt;
  logic          ovf;
  logic          fire;
  logic          full;
  logic          close;

  assign items.ready = push_ready;
  assign push_valid  = items.valid;
  assign fire        = items.valid && push_ready;
  assign full        = items.payload.set_select ? (bcnt == CW'(SET_SIZE))
                                                : (acnt == CW'(SET_SIZE));
  assign close       = items.payload.set_select && items.payload.end_of_set;

  always_comb begin
    push_data.set_select = items.payload.set_select;
    push_data.value      = items.payload.value;
    push_data.keep       = !full;
    push_data.close      = close;
    push_data.overflow   = ovf || full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acnt <= '0;
      bcnt <= '0;
      ovf  <= 1'b0;
    end else if (fire) begin
      if (close) begin
        acnt <= '0;
        bcnt <= '0;
        ovf  <= 1'b0;
      end else if (full) begin
        ovf <= 1'b1;
      end else if (items.payload.set_select) begin
        bcnt <= bcnt + 1'b1;
      end else begin
        acnt <= acnt + 1'b1;
      end
    end
  end

endmodule

/* src/ssi_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ssi_fifo import ssi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  q_entry_t wr_data,
  input  logic     wr_valid,
  output logic     wr_ready,
  output q_entry_t rd_data,
  output logic     rd_valid,
  input  logic     rd_pop
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t      entries [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (fill != NW'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = entries[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

/* src/ssi_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection back end
// Stores both sets, collects first-set values found in the second set, then
// emits the distinct common values in ascending order by repeated scans.
// ----------------------------------------------------------------------------
module ssi_back import ssi_pkg::*; #(
  parameter int SET_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  q_entry_t    q_data,
  input  logic        q_valid,
  output logic        q_pop,
  ssi_result_if.source results
);

  localparam int CW = $clog2(SET_SIZE + 1);
  localparam int AW = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;

  back_state_t state;
  back_state_t state_next;

  logic signed [31:0] mem_a [SET_SIZE];
  logic signed [31:0] mem_b [SET_SIZE];
  logic signed [31:0] mem_c [SET_SIZE];
  logic signed [31:0] rd_a;
  logic signed [31:0] rd_b;
  logic signed [31:0] rd_c;

  logic [CW-1:0]      acnt;
  logic [CW-1:0]      bcnt;
  logic [CW-1:0]      ccnt;
  logic [CW-1:0]      i;
  logic [CW-1:0]      j;
  logic [CW-1:0]      k;
  logic               pv;
  logic               found;
  logic signed [31:0] best;
  logic               have_held;
  logic signed [31:0] held;
  logic [RCW-1:0]     ecnt;
  logic               ovf_run;
  out_item_t          pend;
  logic               pend_final;
  logic               out_valid;
  out_item_t          out_item;

  logic hit_b;
  logic build_b_done;
  logic scan_done;
  logic cand_ok;
  logic slot_free;
  logic a_read;
  logic b_read;
  logic c_read;
  logic c_write;
  logic build_end;
  logic first_found;
  logic scan_start;
  logic scan_emit;
  logic out_load;
  logic run_end;

  assign hit_b        = pv && (rd_b == rd_a);
  assign build_b_done = hit_b || ((j == bcnt) && !pv);
  assign scan_done    = (k == ccnt) && !pv;
  assign cand_ok      = pv && (!have_held || (rd_c > held)) && (!found || (rd_c < best));
  assign slot_free    = !out_valid || results.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (q_valid && q_data.close) state_next = ST_BUILD_A;
      end
      ST_BUILD_A: begin
        state_next = (i == acnt) ? ST_SCAN : ST_BUILD_B;
      end
      ST_BUILD_B: begin
        if (build_b_done) state_next = ST_BUILD_A;
      end
      ST_SCAN: begin
        if (scan_done) state_next = (!have_held && found) ? ST_SCAN : ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) state_next = pend_final ? ST_LOAD : ST_SCAN;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    q_pop       = 1'b0;
    a_read      = 1'b0;
    b_read      = 1'b0;
    c_read      = 1'b0;
    c_write     = 1'b0;
    build_end   = 1'b0;
    first_found = 1'b0;
    scan_emit   = 1'b0;
    out_load    = 1'b0;
    case (state)
      ST_LOAD: begin
        q_pop = q_valid;
      end
      ST_BUILD_A: begin
        a_read    = (i != acnt);
        build_end = (i == acnt);
      end
      ST_BUILD_B: begin
        b_read  = (j != bcnt) && !hit_b;
        c_write = hit_b;
      end
      ST_SCAN: begin
        c_read      = (k != ccnt);
        first_found = scan_done && !have_held && found;
        scan_emit   = scan_done && !(!have_held && found);
      end
      ST_PUSH: begin
        out_load = slot_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  assign scan_start = build_end || first_found || (out_load && !pend_final);
  assign run_end    = out_load && pend_final;

  always_ff @(posedge clk) begin
    if (q_pop && q_data.keep) begin
      if (q_data.set_select) begin
        mem_b[bcnt[AW-1:0]] <= q_data.value;
      end else begin
        mem_a[acnt[AW-1:0]] <= q_data.value;
      end
    end
    if (c_write) begin
      mem_c[ccnt[AW-1:0]] <= rd_a;
    end
    if (a_read) begin
      rd_a <= mem_a[i[AW-1:0]];
    end
    if (b_read) begin
      rd_b <= mem_b[j[AW-1:0]];
    end
    if (c_read) begin
      rd_c <= mem_c[k[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      acnt      <= '0;
      bcnt      <= '0;
      ccnt      <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pv    <= b_read || c_read;
      if (run_end) begin
        acnt <= '0;
        bcnt <= '0;
        ccnt <= '0;
      end else begin
        if (q_pop && q_data.keep) begin
          if (q_data.set_select) begin
            bcnt <= bcnt + 1'b1;
          end else begin
            acnt <= acnt + 1'b1;
          end
        end
        if (c_write) begin
          ccnt <= ccnt + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.close) begin
      i       <= '0;
      ovf_run <= q_data.overflow;
    end else if (state == ST_BUILD_B && build_b_done) begin
      i <= i + 1'b1;
    end
    if (a_read) begin
      j <= '0;
    end else if (b_read) begin
      j <= j + 1'b1;
    end
    if (scan_start) begin
      k     <= '0;
      found <= 1'b0;
    end else begin
      if (c_read) begin
        k <= k + 1'b1;
      end
      if (cand_ok) begin
        found <= 1'b1;
        best  <= rd_c;
      end
    end
    if (build_end) begin
      have_held <= 1'b0;
      ecnt      <= '0;
    end else if (first_found) begin
      have_held <= 1'b1;
      held      <= best;
    end else if (scan_emit && have_held) begin
      held <= best;
      ecnt <= ecnt + 1'b1;
    end
    if (scan_emit) begin
      if (!have_held) begin
        pend.common_value  <= '0;
        pend.last_result   <= 1'b1;
        pend.empty_result  <= 1'b1;
        pend.overflow_seen <= ovf_run;
        pend_final         <= 1'b1;
      end else begin
        pend.common_value  <= held;
        pend.last_result   <= !found || (ecnt == RCW'(MAX_RESULTS - 1));
        pend.empty_result  <= 1'b0;
        pend.overflow_seen <= ovf_run;
        pend_final         <= !found || (ecnt == RCW'(MAX_RESULTS - 1));
      end
    end
    if (out_load) begin
      out_item <= pend;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_item;

endmodule

/* src/sorted_set_intersection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection
// Loads two sets of signed words and emits their distinct common values in
// ascending order, at most MAX_RESULTS of them, or a single empty result.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transaction
//  items     in         set_select, value, end_of_set
//  results   out        common_value, last_result, empty_result, overflow_seen
//
// One transaction per cycle is accepted while the four-entry queue has room.
// A closing transaction starts a membership pass of the stored first set against
// the second set, then repeated ordered scans of the common values.
// Reset clears counters and handshake state; the memories need no clearing.
// A stalled result holds the back end, and input stalls once the queue fills.
module sorted_set_intersection import ssi_pkg::*; #(
  parameter int SET_SIZE = 32
) (
  input  logic          clk,
  input  logic          rst,
  ssi_item_if.sink      items,
  ssi_result_if.source  results
);

  q_entry_t push_data;
  logic     push_valid;
  logic     push_ready;
  q_entry_t q_data;
  logic     q_valid;
  logic     q_pop;

  ssi_front #(.SET_SIZE(SET_SIZE)) u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  ssi_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_data  (push_data),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .rd_data  (q_data),
    .rd_valid (q_valid),
    .rd_pop   (q_pop)
  );

  ssi_back #(.SET_SIZE(SET_SIZE)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

/* src/ssi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted set intersection checker
// Port-level checks on result ordering and flags within a run.
// ----------------------------------------------------------------------------
module ssi_checker import ssi_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      res_valid,
  input logic      res_ready,
  input out_item_t res_item
);

  logic               res_fire;
  logic               in_run;
  logic signed [31:0] prev_value;
  logic               prev_ovf;

  assign res_fire = res_valid && res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run <= 1'b0;
    end else if (res_fire) begin
      in_run     <= !res_item.last_result;
      prev_value <= res_item.common_value;
      prev_ovf   <= res_item.overflow_seen;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_item))
    else $error("result changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.empty_result |->
      res_item.last_result && res_item.common_value == 32'sd0)
    else $error("empty result not final or not zero");

  a_order: assert property (@(posedge clk) disable iff (rst)
    res_fire && in_run |-> !res_item.empty_result && res_item.common_value > prev_value)
    else $error("results not strictly ascending");

  a_ovf: assert property (@(posedge clk) disable iff (rst)
    res_fire && in_run |-> res_item.overflow_seen == prev_ovf)
    else $error("overflow flag changed within a run");

endmodule

bind sorted_set_intersection ssi_checker u_ssi_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_item  (results.payload)
);
